// ----- design/ltip_pkg.sv -----
// shared types and codes for the lldp tlv id parser
package ltip_pkg;

    // one input beat: a single lldpdu byte plus frame markers
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
    } item_t;

    // one result beat, one per frame
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] chassis_id;
        logic        chassis_found;
        logic [15:0] port_id;
        logic        port_found;
    } result_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR0,
        PH_HDR1,
        PH_SUBT,
        PH_SKIP,
        PH_NUM
    } phase_t;

    typedef enum logic [2:0] {
        NM_NONE,
        NM_ZERO,
        NM_HEXP,
        NM_HEX,
        NM_OCT,
        NM_DEC,
        NM_BAD,
        NM_STOP
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_TRUNC_HDR,
        ST_TRUNC_VAL,
        ST_UNKNOWN_TYPE,
        ST_BAD_CHASSIS,
        ST_BAD_PORT
    } status_t;

    // number parser state carried between bytes
    typedef struct packed {
        mode_t       mode;
        logic        sat;
        logic [63:0] acc;
    } num_state_t;

    localparam logic [6:0] TLV_END     = 7'd0;
    localparam logic [6:0] TLV_CHASSIS = 7'd1;
    localparam logic [6:0] TLV_PORT    = 7'd2;
    localparam logic [6:0] TLV_TTL     = 7'd3;
    localparam logic [7:0] SUBTYPE_LOCAL = 8'd7;

endpackage

// ----- design/lldp_tlv_id_parser_core.sv -----
// an accepted byte beat is held in the byte register and updates the parser and result registers from there
// throughput: one byte beat per cycle while the result is not stalled, set by the single-pass byte update stage
// a stalled result holds the byte stage and the input, nothing else slows the block
// reset (rst_n low, async): parser idle and out of frame, all parser state cleared,
// no beats held in the byte or result register
module lldp_tlv_id_parser_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ltip_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_ready,
    output ltip_pkg::result_t result
);
    import ltip_pkg::*;

    // ---------------------------------------------------------------
    // input register stage
    // ---------------------------------------------------------------
    logic    byte_valid_reg;
    logic    byte_valid_next;
    item_t   byte_reg;
    item_t   byte_next;
    logic    step_go;
    logic    step_fire;

    // the byte stage only moves when the result register can take a result
    assign step_go    = !(result_valid && !result_ready);
    assign step_fire  = byte_valid_reg && step_go;
    assign item_ready = !byte_valid_reg || step_go;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        byte_next       = byte_reg;
        if (item_ready)
        begin
            byte_valid_next = item_valid;
            if (item_valid)
                byte_next = item;
        end
    end

    // ---------------------------------------------------------------
    // parser state
    // ---------------------------------------------------------------
    phase_t      phase_reg,   phase_next;
    logic [7:0]  hdr_reg,     hdr_next;
    logic [6:0]  kind_reg,    kind_next;
    logic [8:0]  left_reg,    left_next;
    num_state_t  num_reg,     num_next;
    logic [63:0] chassis_reg, chassis_next;
    logic [15:0] port_reg,    port_next;
    logic [1:0]  found_reg,   found_next;
    logic        done_reg,    done_next;

    // result register
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg,       result_next;

    num_state_t  num_base;
    num_state_t  num_step;
    logic        made;
    status_t     made_status;
    logic        finish;
    logic [63:0] num_value;

    // digit unit works from the number state as it stands this byte
    ltip_digit_step u_digit (
        .cur (num_base),
        .ch  (byte_reg.data_byte),
        .nxt (num_step)
    );

    always_comb
    begin
        num_base = num_reg;
        if (byte_reg.frame_start)
            num_base = '{mode: NM_NONE, sat: 1'b0, acc: 64'd0};
    end

    // one byte through the tlv walker
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_next     = hdr_reg;
        kind_next    = kind_reg;
        left_next    = left_reg;
        num_next     = num_reg;
        chassis_next = chassis_reg;
        port_next    = port_reg;
        found_next   = found_reg;
        done_next    = done_reg;
        made         = 1'b0;
        made_status  = ST_OK;
        finish       = 1'b0;
        num_value    = 64'd0;

        if (step_fire)
        begin
            // a frame start wipes everything and restarts at the first header byte
            if (byte_reg.frame_start)
            begin
                hdr_next     = 8'd0;
                kind_next    = 7'd0;
                left_next    = 9'd0;
                num_next     = num_base;
                chassis_next = 64'd0;
                port_next    = 16'd0;
                found_next   = 2'b00;
                done_next    = 1'b0;
                phase_next   = PH_HDR0;
            end

            if (!done_next)
            begin
                case (phase_next)
                    PH_HDR0:
                    begin
                        hdr_next   = byte_reg.data_byte;
                        phase_next = PH_HDR1;
                    end
                    PH_HDR1:
                    begin
                        kind_next = hdr_next[7:1];
                        left_next = {hdr_next[0], byte_reg.data_byte};
                        if (left_next == 9'd0)
                            finish = 1'b1;
                        else if ((kind_next == TLV_CHASSIS) || (kind_next == TLV_PORT))
                            phase_next = PH_SUBT;
                        else
                            phase_next = PH_SKIP;
                    end
                    PH_SUBT:
                    begin
                        left_next = left_next - 9'd1;
                        if (byte_reg.data_byte == SUBTYPE_LOCAL)
                        begin
                            phase_next = PH_NUM;
                            num_next   = '{mode: NM_NONE, sat: 1'b0, acc: 64'd0};
                        end
                        else
                            phase_next = PH_SKIP;
                        finish = (left_next == 9'd0);
                    end
                    PH_NUM:
                    begin
                        num_next  = num_step;
                        left_next = left_next - 9'd1;
                        finish    = (left_next == 9'd0);
                    end
                    default:
                    begin
                        left_next = left_next - 9'd1;
                        finish    = (left_next == 9'd0);
                    end
                endcase

                // tlv value complete: judge type, commit a parsed id
                if (finish)
                begin
                    num_value = num_next.sat ? '1 : num_next.acc;
                    if (kind_next > TLV_TTL)
                    begin
                        made        = 1'b1;
                        made_status = ST_UNKNOWN_TYPE;
                    end
                    else if ((phase_next == PH_NUM)
                             && (num_next.mode inside {NM_BAD, NM_HEXP}))
                    begin
                        made        = 1'b1;
                        made_status = (kind_next == TLV_CHASSIS) ? ST_BAD_CHASSIS
                                                                 : ST_BAD_PORT;
                    end
                    else
                    begin
                        if (phase_next == PH_NUM)
                        begin
                            if (kind_next == TLV_CHASSIS)
                            begin
                                chassis_next  = num_value;
                                found_next[0] = 1'b1;
                            end
                            else
                            begin
                                port_next     = num_value[15:0];
                                found_next[1] = 1'b1;
                            end
                        end
                        if (kind_next == TLV_END)
                        begin
                            made        = 1'b1;
                            made_status = ST_OK;
                        end
                        else
                            phase_next = PH_HDR0;
                    end
                end

                // frame ran out before an end tlv
                if (!made && byte_reg.frame_end)
                begin
                    made        = 1'b1;
                    made_status = ((phase_next == PH_HDR0) || (phase_next == PH_HDR1))
                                  ? ST_TRUNC_HDR : ST_TRUNC_VAL;
                end

                if (made)
                begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    // result register with hold while the consumer stalls
    always_comb
    begin
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        if (made)
        begin
            result_valid_next         = 1'b1;
            result_next.status        = made_status;
            result_next.chassis_id    = (made_status == ST_OK) ? chassis_next : 64'd0;
            result_next.chassis_found = (made_status == ST_OK) && found_next[0];
            result_next.port_id       = (made_status == ST_OK) ? port_next : 16'd0;
            result_next.port_found    = (made_status == ST_OK) && found_next[1];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            phase_reg        <= PH_IDLE;
            hdr_reg          <= 8'd0;
            kind_reg         <= 7'd0;
            left_reg         <= 9'd0;
            num_reg          <= '{mode: NM_NONE, sat: 1'b0, acc: 64'd0};
            chassis_reg      <= 64'd0;
            port_reg         <= 16'd0;
            found_reg        <= 2'b00;
            done_reg         <= 1'b1;
        end
        else
        begin
            byte_valid_reg   <= byte_valid_next;
            result_valid_reg <= result_valid_next;
            phase_reg        <= phase_next;
            hdr_reg          <= hdr_next;
            kind_reg         <= kind_next;
            left_reg         <= left_next;
            num_reg          <= num_next;
            chassis_reg      <= chassis_next;
            port_reg         <= port_next;
            found_reg        <= found_next;
            done_reg         <= done_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        result_reg <= result_next;
    end

endmodule

// ----- design/ltip_digit_step.sv -----
// one character step of the base auto-detecting number parser
module ltip_digit_step (
    input  ltip_pkg::num_state_t cur,
    input  logic [7:0]           ch,
    output ltip_pkg::num_state_t nxt
);
    import ltip_pkg::*;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_1   = 8'h31;
    localparam logic [7:0] CH_7   = 8'h37;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LF  = 8'h66;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;
    localparam logic [7:0] CH_LX  = 8'h78;
    localparam logic [7:0] CH_UX  = 8'h58;

    typedef enum logic [1:0] {
        BASE_8,
        BASE_10,
        BASE_16
    } base_t;

    logic        is_dec;
    logic        is_oct;
    logic        is_hex;
    logic [3:0]  hex_val;
    logic [3:0]  digit;
    base_t       base;
    logic        do_add;
    mode_t       new_mode;
    logic [67:0] acc_w;
    logic [67:0] scaled;
    logic [67:0] sum;

    always_comb
    begin
        is_dec = (ch >= CH_0) && (ch <= CH_9);
        is_oct = (ch >= CH_0) && (ch <= CH_7);
        hex_val = 4'd0;
        is_hex = 1'b1;
        if (is_dec)
        begin
            hex_val = ch[3:0];
        end
        else if ((ch >= CH_LA) && (ch <= CH_LF))
        begin
            hex_val = 4'(ch - CH_LA + 8'd10);
        end
        else if ((ch >= CH_UA) && (ch <= CH_UF))
        begin
            hex_val = 4'(ch - CH_UA + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // mode transitions and digit selection
    always_comb
    begin
        new_mode = cur.mode;
        do_add   = 1'b0;
        digit    = ch[3:0];
        base     = BASE_10;
        case (cur.mode)
            NM_NONE:
            begin
                if (ch == CH_NUL)
                    new_mode = NM_STOP;
                else if (ch == CH_0)
                    new_mode = NM_ZERO;
                else if ((ch >= CH_1) && (ch <= CH_9))
                begin
                    new_mode = NM_DEC;
                    do_add   = 1'b1;
                end
                else
                    new_mode = NM_BAD;
            end
            NM_ZERO, NM_OCT:
            begin
                base = BASE_8;
                if (ch == CH_NUL)
                    new_mode = NM_STOP;
                else if ((cur.mode == NM_ZERO) && ((ch == CH_LX) || (ch == CH_UX)))
                    new_mode = NM_HEXP;
                else if (is_oct)
                begin
                    new_mode = NM_OCT;
                    do_add   = 1'b1;
                end
                else
                    new_mode = NM_BAD;
            end
            NM_HEXP, NM_HEX:
            begin
                base  = BASE_16;
                digit = hex_val;
                if ((ch == CH_NUL) && (cur.mode == NM_HEX))
                    new_mode = NM_STOP;
                else if (is_hex)
                begin
                    new_mode = NM_HEX;
                    do_add   = 1'b1;
                end
                else
                    new_mode = NM_BAD;
            end
            NM_DEC:
            begin
                if (ch == CH_NUL)
                    new_mode = NM_STOP;
                else if (is_dec)
                    do_add = 1'b1;
                else
                    new_mode = NM_BAD;
            end
            default:
            begin
                new_mode = cur.mode;
            end
        endcase
    end

    // constant multiply by shifts, overflow shows up in the top four bits
    always_comb
    begin
        acc_w = {4'd0, cur.acc};
        case (base)
            BASE_8:  scaled = acc_w << 3;
            BASE_16: scaled = acc_w << 4;
            default: scaled = (acc_w << 3) + (acc_w << 1);
        endcase
        sum = scaled + {64'd0, digit};

        nxt.mode = new_mode;
        nxt.sat  = cur.sat;
        nxt.acc  = cur.acc;
        if (do_add && !cur.sat)
        begin
            if (sum[67:64] != 4'd0)
            begin
                nxt.sat = 1'b1;
                nxt.acc = '1;
            end
            else
            begin
                nxt.acc = sum[63:0];
            end
        end
    end

endmodule
